// ----- sv/cgps_pkg.sv -----
// ----------------------------------------------------------------------------
// cgps_pkg
// Shared types, widths and constants of the central gravity particle step.
// ----------------------------------------------------------------------------
package cgps_pkg;

  localparam int FRAC_BITS = 12;
  localparam int DATA_W    = 24;
  localparam int MAG_W     = 25;   // |center - position|
  localparam int D2_W      = 51;   // squared distance, Q.2F
  localparam int ROOT_W    = 26;   // distance, Q.F
  localparam int FORCE_W   = 38;   // gravity / d2, Q.F
  localparam int SPLIT_W   = 19;   // half of the force for the partial products
  localparam int PROD_W    = 63;   // force * |d|
  localparam int ACC_W     = 39;   // force * |d| / dist

  localparam int SQRT_STAGES = 26;
  localparam int FDIV_STAGES = 38;
  localparam int ADIV_STAGES = 39;

  localparam int ADDR_W = 5;

  localparam logic [D2_W-1:0] NEAR_EPS =
    D2_W'(((64'd1 << (2 * FRAC_BITS)) + 64'd5000) / 64'd10000);

  localparam logic signed [44:0] SAT_MAX = 45'sd8388607;
  localparam logic signed [44:0] SAT_MIN = -45'sd8388608;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_CENTER_X = 3'd0;
  localparam logic [2:0] REG_CENTER_Y = 3'd1;
  localparam logic [2:0] REG_HORIZON  = 3'd2;
  localparam logic [2:0] REG_GRAVITY  = 3'd3;
  localparam logic [2:0] REG_TIME_STEP = 3'd4;
  localparam logic [2:0] REG_FIELD_W  = 3'd5;
  localparam logic [2:0] REG_FIELD_H  = 3'd6;

  localparam logic [23:0] RST_CENTER_X  = 24'd163840;
  localparam logic [23:0] RST_CENTER_Y  = 24'd81920;
  localparam logic [23:0] RST_HORIZON   = 24'd10240;
  localparam logic [23:0] RST_GRAVITY   = 24'd3276800;
  localparam logic [15:0] RST_TIME_STEP = 16'd328;
  localparam logic [11:0] RST_FIELD_W   = 12'd80;
  localparam logic [11:0] RST_FIELD_H   = 12'd40;

  typedef enum logic [1:0] {
    FATE_ACTIVE   = 2'd0,
    FATE_ABSORBED = 2'd1,
    FATE_LEFT     = 2'd2
  } fate_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] vel_x;
    logic signed [DATA_W-1:0] vel_y;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] new_pos_x;
    logic signed [DATA_W-1:0] new_pos_y;
    logic signed [DATA_W-1:0] new_vel_x;
    logic signed [DATA_W-1:0] new_vel_y;
    logic [1:0]               fate;
    logic [11:0]              cell_column;
    logic [11:0]              cell_row;
  } out_t;

  // sideband that rides along the acceleration divider
  typedef struct packed {
    in_t  item;
    logic sx;        // center_x - pos_x is negative
    logic sy;
    logic absorbed;
  } side_t;

  // clamp to the signed 24-bit range
  function automatic logic signed [DATA_W-1:0] sat24(input logic signed [44:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[DATA_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- sv/cgps_accel_div.sv -----
// ----------------------------------------------------------------------------
// cgps_accel_div
// Pipelined restoring divider: both acceleration numerators over the shared
// distance, one quotient bit per stage.
// ----------------------------------------------------------------------------
module cgps_accel_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  cgps_pkg::side_t                 side_i,
  input  logic [cgps_pkg::PROD_W-1:0]     num_x_i,
  input  logic [cgps_pkg::PROD_W-1:0]     num_y_i,
  input  logic [cgps_pkg::ROOT_W-1:0]     den_i,
  output logic                            valid_o,
  output cgps_pkg::side_t                 side_o,
  output logic [cgps_pkg::ACC_W-1:0]      quo_x_o,
  output logic [cgps_pkg::ACC_W-1:0]      quo_y_o
);

  localparam int N  = cgps_pkg::ADIV_STAGES;
  localparam int RW = cgps_pkg::ROOT_W + 1;

  logic [N-1:0]                      vld_q;
  cgps_pkg::side_t                   side_q  [N];
  logic [RW-1:0]                     rem_x_q [N];
  logic [RW-1:0]                     rem_y_q [N];
  logic [N-1:0]                      lo_x_q  [N];
  logic [N-1:0]                      lo_y_q  [N];
  logic [N-1:0]                      quo_x_q [N];
  logic [N-1:0]                      quo_y_q [N];
  logic [cgps_pkg::ROOT_W-1:0]       den_q   [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic                        v_in;
    cgps_pkg::side_t             side_in;
    logic [RW-1:0]               rx_in, ry_in, tx, ty, den_ext;
    logic [N-1:0]                lx_in, ly_in, qx_in, qy_in;
    logic [cgps_pkg::ROOT_W-1:0] den_in;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign side_in = side_i;
      assign rx_in   = RW'(num_x_i[cgps_pkg::PROD_W-1:N]);
      assign ry_in   = RW'(num_y_i[cgps_pkg::PROD_W-1:N]);
      assign lx_in   = num_x_i[N-1:0];
      assign ly_in   = num_y_i[N-1:0];
      assign qx_in   = '0;
      assign qy_in   = '0;
      assign den_in  = den_i;
    end else begin : g_next
      assign v_in    = vld_q[k-1];
      assign side_in = side_q[k-1];
      assign rx_in   = rem_x_q[k-1];
      assign ry_in   = rem_y_q[k-1];
      assign lx_in   = lo_x_q[k-1];
      assign ly_in   = lo_y_q[k-1];
      assign qx_in   = quo_x_q[k-1];
      assign qy_in   = quo_y_q[k-1];
      assign den_in  = den_q[k-1];
    end

    // shift in the next numerator bit
    assign tx      = {rx_in[RW-2:0], lx_in[N-1-k]};
    assign ty      = {ry_in[RW-2:0], ly_in[N-1-k]};
    assign den_ext = {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= side_in;
        lo_x_q[k] <= lx_in;
        lo_y_q[k] <= ly_in;
        den_q[k]  <= den_in;
        if (tx >= den_ext) begin
          rem_x_q[k] <= tx - den_ext;
          quo_x_q[k] <= {qx_in[N-2:0], 1'b1};
        end else begin
          rem_x_q[k] <= tx;
          quo_x_q[k] <= {qx_in[N-2:0], 1'b0};
        end
        if (ty >= den_ext) begin
          rem_y_q[k] <= ty - den_ext;
          quo_y_q[k] <= {qy_in[N-2:0], 1'b1};
        end else begin
          rem_y_q[k] <= ty;
          quo_y_q[k] <= {qy_in[N-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = vld_q[N-1];
  assign side_o  = side_q[N-1];
  assign quo_x_o = quo_x_q[N-1];
  assign quo_y_o = quo_y_q[N-1];

endmodule

// ----- sv/central_gravity_particle_step_top.sv -----
// ----------------------------------------------------------------------------
// central_gravity_particle_step_top
// One Euler step of a particle around a fixed attractor, in fixed point.
//
//   channel   direction  handshake               payload
//   in        input      in_valid_i / in_stall_o   cgps_pkg::in_t  (pos, vel)
//   out       output     out_valid_o / out_stall_i cgps_pkg::out_t (pos, vel,
//                                                   fate, cell)
//   config    input      APB psel/penable/pwrite  7 registers at 4*index
//
// One request enters per cycle while the output is not stalled; the path runs
// through the 38-stage force divider (square root runs beside it) and the
// 39-stage acceleration divider. Reset clears all valid bits and loads the register defaults.
// A stalled output freezes the whole pipeline; in_stall_o then rises, and
// nothing is lost or repeated.
// ----------------------------------------------------------------------------
module central_gravity_particle_step_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cgps_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  cgps_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output cgps_pkg::out_t                out_data_o
);

  localparam int F  = cgps_pkg::FRAC_BITS;
  localparam int NP = cgps_pkg::FDIV_STAGES;

  typedef struct packed {
    cgps_pkg::in_t                item;
    logic                         sx;
    logic                         sy;
    logic [cgps_pkg::MAG_W-1:0]   adx;
    logic [cgps_pkg::MAG_W-1:0]   ady;
  } front_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [23:0] center_x_q, center_y_q, horizon_q, gravity_q;
  logic [15:0] time_step_q;
  logic [11:0] field_w_q, field_h_q;
  logic [2:0]  reg_idx;
  logic        cfg_we;

  assign pready  = 1'b1;
  assign reg_idx = paddr[cgps_pkg::ADDR_W-1:2];
  assign cfg_we  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q  <= cgps_pkg::RST_CENTER_X;
      center_y_q  <= cgps_pkg::RST_CENTER_Y;
      horizon_q   <= cgps_pkg::RST_HORIZON;
      gravity_q   <= cgps_pkg::RST_GRAVITY;
      time_step_q <= cgps_pkg::RST_TIME_STEP;
      field_w_q   <= cgps_pkg::RST_FIELD_W;
      field_h_q   <= cgps_pkg::RST_FIELD_H;
    end else if (cfg_we) begin
      case (reg_idx)
        cgps_pkg::REG_CENTER_X:  center_x_q  <= pwdata[23:0];
        cgps_pkg::REG_CENTER_Y:  center_y_q  <= pwdata[23:0];
        cgps_pkg::REG_HORIZON:   horizon_q   <= pwdata[23:0];
        cgps_pkg::REG_GRAVITY:   gravity_q   <= pwdata[23:0];
        cgps_pkg::REG_TIME_STEP: time_step_q <= pwdata[15:0];
        cgps_pkg::REG_FIELD_W:   field_w_q   <= pwdata[11:0];
        cgps_pkg::REG_FIELD_H:   field_h_q   <= pwdata[11:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      cgps_pkg::REG_CENTER_X:  prdata = {8'h00, center_x_q};
      cgps_pkg::REG_CENTER_Y:  prdata = {8'h00, center_y_q};
      cgps_pkg::REG_HORIZON:   prdata = {8'h00, horizon_q};
      cgps_pkg::REG_GRAVITY:   prdata = {8'h00, gravity_q};
      cgps_pkg::REG_TIME_STEP: prdata = {16'h0000, time_step_q};
      cgps_pkg::REG_FIELD_W:   prdata = {20'h00000, field_w_q};
      cgps_pkg::REG_FIELD_H:   prdata = {20'h00000, field_h_q};
      default:                 prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Flow control: every stage advances together unless the result is held
  // --------------------------------------------------------------------------
  logic out_vld_q;
  logic advance;

  assign advance    = !(out_vld_q && out_stall_i);
  assign in_stall_o = !advance;

  // --------------------------------------------------------------------------
  // Stage A: offsets to the center and their magnitudes
  // --------------------------------------------------------------------------
  logic signed [25:0] dx, dy;
  logic               a_vld_q;
  front_t             a_side_q;

  assign dx = $signed({2'b00, center_x_q})
            - $signed({{2{in_data_i.pos_x[23]}}, in_data_i.pos_x});
  assign dy = $signed({2'b00, center_y_q})
            - $signed({{2{in_data_i.pos_y[23]}}, in_data_i.pos_y});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (advance) begin
      a_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      a_side_q.item <= in_data_i;
      a_side_q.sx   <= dx[25];
      a_side_q.sy   <= dy[25];
      a_side_q.adx  <= dx[25] ? cgps_pkg::MAG_W'(-dx) : cgps_pkg::MAG_W'(dx);
      a_side_q.ady  <= dy[25] ? cgps_pkg::MAG_W'(-dy) : cgps_pkg::MAG_W'(dy);
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: squares; stage C: squared distance
  // --------------------------------------------------------------------------
  logic                          b_vld_q, c_vld_q;
  front_t                        b_side_q, c_side_q;
  logic [2*cgps_pkg::MAG_W-1:0]  sqx, sqy, b_sqx_q, b_sqy_q;
  logic [cgps_pkg::D2_W-1:0]     c_d2_q;

  assign sqx = a_side_q.adx * a_side_q.adx;
  assign sqy = a_side_q.ady * a_side_q.ady;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else if (advance) begin
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      b_side_q <= a_side_q;
      b_sqx_q  <= sqx;
      b_sqy_q  <= sqy;
      c_side_q <= b_side_q;
      c_d2_q   <= cgps_pkg::D2_W'(b_sqx_q) + cgps_pkg::D2_W'(b_sqy_q);
    end
  end

  // --------------------------------------------------------------------------
  // Stages P0..P37: force = (gravity << 2F) / d2, one quotient bit a stage;
  // the square root of d2 runs in the first 26 of them, one root bit a stage.
  // --------------------------------------------------------------------------
  logic [NP-1:0]                  p_vld_q;
  front_t                         p_side_q [NP];
  logic [cgps_pkg::D2_W-1:0]      p_d2_q   [NP];
  logic [cgps_pkg::D2_W-1:0]      p_sv_q   [NP];
  logic [cgps_pkg::D2_W:0]        p_sr_q   [NP];
  logic [cgps_pkg::D2_W:0]        p_fr_q   [NP];
  logic [cgps_pkg::FORCE_W-1:0]   p_fq_q   [NP];

  for (genvar k = 0; k < NP; k++) begin : g_p
    logic                         v_in, nbit;
    front_t                       side_in;
    logic [cgps_pkg::D2_W-1:0]    d2_in, sv_in, sv_d;
    logic [cgps_pkg::D2_W:0]      sr_in, fr_in, sr_d, ftrial, d2_ext;
    logic [cgps_pkg::FORCE_W-1:0] fq_in;

    if (k == 0) begin : g_first
      assign v_in    = c_vld_q;
      assign side_in = c_side_q;
      assign d2_in   = c_d2_q;
      assign sv_in   = c_d2_q;
      assign sr_in   = '0;
      // numerator bits above the quotient range seed the remainder
      assign fr_in   = (cgps_pkg::D2_W + 1)'(gravity_q[23:NP-2*F]);
      assign fq_in   = '0;
    end else begin : g_next
      assign v_in    = p_vld_q[k-1];
      assign side_in = p_side_q[k-1];
      assign d2_in   = p_d2_q[k-1];
      assign sv_in   = p_sv_q[k-1];
      assign sr_in   = p_sr_q[k-1];
      assign fr_in   = p_fr_q[k-1];
      assign fq_in   = p_fq_q[k-1];
    end

    if (NP - 1 - k >= 2 * F) begin : g_gbit
      assign nbit = gravity_q[NP-1-k-2*F];
    end else begin : g_zbit
      assign nbit = 1'b0;
    end

    assign ftrial = {fr_in[cgps_pkg::D2_W-1:0], nbit};
    assign d2_ext = {1'b0, d2_in};

    if (k < cgps_pkg::SQRT_STAGES) begin : g_sqrt
      localparam logic [cgps_pkg::D2_W:0] BIT = (cgps_pkg::D2_W + 1)'(1) << (50 - 2 * k);
      always_comb begin
        if ({1'b0, sv_in} >= sr_in + BIT) begin
          sv_d = sv_in - cgps_pkg::D2_W'(sr_in + BIT);
          sr_d = (sr_in >> 1) + BIT;
        end else begin
          sv_d = sv_in;
          sr_d = sr_in >> 1;
        end
      end
    end else begin : g_hold
      assign sv_d = sv_in;
      assign sr_d = sr_in;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        p_vld_q[k] <= 1'b0;
      end else if (advance) begin
        p_vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (advance) begin
        p_side_q[k] <= side_in;
        p_d2_q[k]   <= d2_in;
        p_sv_q[k]   <= sv_d;
        p_sr_q[k]   <= sr_d;
        if (ftrial >= d2_ext) begin
          p_fr_q[k] <= ftrial - d2_ext;
          p_fq_q[k] <= {fq_in[cgps_pkg::FORCE_W-2:0], 1'b1};
        end else begin
          p_fr_q[k] <= ftrial;
          p_fq_q[k] <= {fq_in[cgps_pkg::FORCE_W-2:0], 1'b0};
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage M1: absorption test and force * |d| as split partial products
  // Stage M2: sum the partial products
  // --------------------------------------------------------------------------
  localparam int PPW = cgps_pkg::SPLIT_W + cgps_pkg::MAG_W;

  logic [cgps_pkg::ROOT_W-1:0]  dist_v;
  logic [cgps_pkg::FORCE_W-1:0] force_v;
  logic                         absorbed;
  front_t                       p_last;

  assign p_last   = p_side_q[NP-1];
  assign dist_v   = p_sr_q[NP-1][cgps_pkg::ROOT_W-1:0];
  assign force_v  = p_fq_q[NP-1];
  assign absorbed = (p_d2_q[NP-1] < cgps_pkg::NEAR_EPS) || (dist_v == '0)
                 || (dist_v < {2'b00, horizon_q});

  logic                         m1_vld_q, m2_vld_q;
  cgps_pkg::side_t              m1_side_q, m2_side_q;
  logic [cgps_pkg::ROOT_W-1:0]  m1_dist_q, m2_dist_q;
  logic [PPW-1:0]               m1_xl_q, m1_xh_q, m1_yl_q, m1_yh_q;
  logic [cgps_pkg::PROD_W-1:0]  m2_px_q, m2_py_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_vld_q <= 1'b0;
      m2_vld_q <= 1'b0;
    end else if (advance) begin
      m1_vld_q <= p_vld_q[NP-1];
      m2_vld_q <= m1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      m1_side_q.item     <= p_last.item;
      m1_side_q.sx       <= p_last.sx;
      m1_side_q.sy       <= p_last.sy;
      m1_side_q.absorbed <= absorbed;
      m1_dist_q          <= dist_v;
      m1_xl_q <= force_v[cgps_pkg::SPLIT_W-1:0] * p_last.adx;
      m1_xh_q <= force_v[cgps_pkg::FORCE_W-1:cgps_pkg::SPLIT_W] * p_last.adx;
      m1_yl_q <= force_v[cgps_pkg::SPLIT_W-1:0] * p_last.ady;
      m1_yh_q <= force_v[cgps_pkg::FORCE_W-1:cgps_pkg::SPLIT_W] * p_last.ady;
      m2_side_q <= m1_side_q;
      m2_dist_q <= m1_dist_q;
      m2_px_q   <= {m1_xh_q, {cgps_pkg::SPLIT_W{1'b0}}} + cgps_pkg::PROD_W'(m1_xl_q);
      m2_py_q   <= {m1_yh_q, {cgps_pkg::SPLIT_W{1'b0}}} + cgps_pkg::PROD_W'(m1_yl_q);
    end
  end

  // --------------------------------------------------------------------------
  // Acceleration magnitudes: force * |d| / distance
  // --------------------------------------------------------------------------
  logic                        d_vld;
  cgps_pkg::side_t             d_side;
  logic [cgps_pkg::ACC_W-1:0]  acc_x, acc_y;

  cgps_accel_div u_accel_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (m2_vld_q),
    .side_i  (m2_side_q),
    .num_x_i (m2_px_q),
    .num_y_i (m2_py_q),
    .den_i   (m2_dist_q),
    .valid_o (d_vld),
    .side_o  (d_side),
    .quo_x_o (acc_x),
    .quo_y_o (acc_y)
  );

  // --------------------------------------------------------------------------
  // T1: a * dt; T2: new velocity; T3: v * dt; T4 (output): new position, fate
  // --------------------------------------------------------------------------
  localparam int DVW = cgps_pkg::ACC_W + 16 - F;   // |a * dt| >> F
  localparam int DPW = cgps_pkg::DATA_W + 16 - F;  // |v * dt| >> F

  logic [cgps_pkg::ACC_W+15:0]  dvx_full, dvy_full;
  logic [cgps_pkg::DATA_W+15:0] dpx_full, dpy_full;
  logic [cgps_pkg::DATA_W-1:0]  vmx, vmy;
  logic signed [44:0]           sumvx, sumvy, sumpx, sumpy;
  logic signed [23:0]           npx, npy;
  logic                         left;

  logic                 t1_vld_q, t2_vld_q, t3_vld_q;
  cgps_pkg::side_t      t1_side_q, t2_side_q, t3_side_q;
  logic [DVW-1:0]       t1_dvx_q, t1_dvy_q;
  logic signed [23:0]   t2_vx_q, t2_vy_q, t3_vx_q, t3_vy_q;
  logic [DPW-1:0]       t3_dpx_q, t3_dpy_q;
  cgps_pkg::out_t       out_q;

  assign dvx_full = acc_x * time_step_q;
  assign dvy_full = acc_y * time_step_q;

  assign sumvx = $signed({{21{t1_side_q.item.vel_x[23]}}, t1_side_q.item.vel_x})
               + (t1_side_q.sx ? -$signed({2'b00, t1_dvx_q}) : $signed({2'b00, t1_dvx_q}));
  assign sumvy = $signed({{21{t1_side_q.item.vel_y[23]}}, t1_side_q.item.vel_y})
               + (t1_side_q.sy ? -$signed({2'b00, t1_dvy_q}) : $signed({2'b00, t1_dvy_q}));

  assign vmx      = t2_vx_q[23] ? 24'(-t2_vx_q) : t2_vx_q;
  assign vmy      = t2_vy_q[23] ? 24'(-t2_vy_q) : t2_vy_q;
  assign dpx_full = vmx * time_step_q;
  assign dpy_full = vmy * time_step_q;

  assign sumpx = $signed({{21{t3_side_q.item.pos_x[23]}}, t3_side_q.item.pos_x})
               + (t3_vx_q[23] ? -$signed({17'd0, t3_dpx_q}) : $signed({17'd0, t3_dpx_q}));
  assign sumpy = $signed({{21{t3_side_q.item.pos_y[23]}}, t3_side_q.item.pos_y})
               + (t3_vy_q[23] ? -$signed({17'd0, t3_dpy_q}) : $signed({17'd0, t3_dpy_q}));
  assign npx   = cgps_pkg::sat24(sumpx);
  assign npy   = cgps_pkg::sat24(sumpy);

  // both positions are nonnegative when the upper compares are reached
  assign left = npx[23] || npy[23]
             || (npx[23:0] >= {field_w_q, {F{1'b0}}})
             || (npy[23:0] >= {field_h_q, {F{1'b0}}});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_vld_q  <= 1'b0;
      t2_vld_q  <= 1'b0;
      t3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (advance) begin
      t1_vld_q  <= d_vld;
      t2_vld_q  <= t1_vld_q;
      t3_vld_q  <= t2_vld_q;
      out_vld_q <= t3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      t1_side_q <= d_side;
      t1_dvx_q  <= dvx_full[cgps_pkg::ACC_W+15:F];
      t1_dvy_q  <= dvy_full[cgps_pkg::ACC_W+15:F];
      t2_side_q <= t1_side_q;
      t2_vx_q   <= cgps_pkg::sat24(sumvx);
      t2_vy_q   <= cgps_pkg::sat24(sumvy);
      t3_side_q <= t2_side_q;
      t3_vx_q   <= t2_vx_q;
      t3_vy_q   <= t2_vy_q;
      t3_dpx_q  <= dpx_full[cgps_pkg::DATA_W+15:F];
      t3_dpy_q  <= dpy_full[cgps_pkg::DATA_W+15:F];
      if (t3_side_q.absorbed) begin
        // hand the particle back as it came in
        out_q.new_pos_x   <= t3_side_q.item.pos_x;
        out_q.new_pos_y   <= t3_side_q.item.pos_y;
        out_q.new_vel_x   <= t3_side_q.item.vel_x;
        out_q.new_vel_y   <= t3_side_q.item.vel_y;
        out_q.fate        <= cgps_pkg::FATE_ABSORBED;
        out_q.cell_column <= '0;
        out_q.cell_row    <= '0;
      end else begin
        out_q.new_pos_x <= npx;
        out_q.new_pos_y <= npy;
        out_q.new_vel_x <= t3_vx_q;
        out_q.new_vel_y <= t3_vy_q;
        if (left) begin
          out_q.fate        <= cgps_pkg::FATE_LEFT;
          out_q.cell_column <= '0;
          out_q.cell_row    <= '0;
        end else begin
          out_q.fate        <= cgps_pkg::FATE_ACTIVE;
          out_q.cell_column <= npx[23:F];
          out_q.cell_row    <= npy[23:F];
        end
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_absorbed_no_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.fate == cgps_pkg::FATE_ABSORBED)
    |-> (out_data_o.cell_column == '0) && (out_data_o.cell_row == '0))
    else $error("absorbed particle reports a cell");

  a_active_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.fate == cgps_pkg::FATE_ACTIVE)
    |-> !out_data_o.new_pos_x[23] && !out_data_o.new_pos_y[23]
        && (out_data_o.cell_column == out_data_o.new_pos_x[23:F])
        && (out_data_o.cell_row == out_data_o.new_pos_y[23:F]))
    else $error("active particle cell does not match its position");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> a_vld_q)
    else $error("accepted request did not enter the pipeline");

endmodule
